/* design/dvsg_pkg.sv */
// ----------------------------------------------------------------------------
// dvsg_pkg
// Shared types, constants and the control program of the vector-shape
// tone generator.
// ----------------------------------------------------------------------------
package dvsg_pkg;

  // Default parameter values
  localparam int PHASE_BITS_DEF  = 32;
  localparam int SINE_DEPTH_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int STEP_W    = 32;
  localparam int OUT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 3;

  // Fixed-point positions
  localparam int RATE_FRAC_BITS = 14;
  localparam int GAIN_FRAC_BITS = 16;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_RATE_MUL,
    REG_STEM_RATE_MUL,
    REG_HAT_RATE_MUL,
    REG_STEM_GAIN,
    REG_HAT_GAIN,
    REG_SCAN_GAIN,
    REG_MASTER_GAIN,
    REG_HAT_FRACTION
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
    16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd16384
  };

  // Sequencer state
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    A_STEP,
    A_SAW,
    A_SINE,
    A_RIGHT,
    A_LEFT
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SCAN_MUL,
    B_STEM_MUL,
    B_HAT_MUL,
    B_SCAN_GAIN,
    B_LEFT_GAIN,
    B_MASTER,
    B_SCAN_SINE
  } b_sel_t;

  // Product retire destinations
  typedef enum logic [2:0] {
    RET_NONE,
    RET_SCAN,
    RET_STEM,
    RET_HAT,
    RET_RIGHT,
    RET_LEFT,
    RET_LEFT_SINE
  } ret_t;

  // Sine table read address selects
  typedef enum logic [1:0] {
    ROM_NONE,
    ROM_SCAN,
    ROM_LEFT
  } rom_sel_t;

  typedef enum logic {
    JMP_NONE,
    JMP_STEM
  } jmp_t;

  // Program addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_SCAN_MUL       = 4'd0;
  localparam logic [UPC_W-1:0] UPC_STEM_MUL       = 4'd1;
  localparam logic [UPC_W-1:0] UPC_HAT_MUL        = 4'd2;
  localparam logic [UPC_W-1:0] UPC_SAW_MUL        = 4'd3;
  localparam logic [UPC_W-1:0] UPC_LEFT_READ      = 4'd4;
  localparam logic [UPC_W-1:0] UPC_RIGHT_MUL      = 4'd5;
  localparam logic [UPC_W-1:0] UPC_LEFT_MUL       = 4'd6;
  localparam logic [UPC_W-1:0] UPC_LEFT_RET       = 4'd7;
  localparam logic [UPC_W-1:0] UPC_SCAN_SINE_MUL  = 4'd8;
  localparam logic [UPC_W-1:0] UPC_SCAN_SINE_RET  = 4'd9;
  localparam logic [UPC_W-1:0] UPC_MASTER_MUL     = 4'd10;
  localparam logic [UPC_W-1:0] UPC_MASTER_RET     = 4'd11;
  localparam logic [UPC_W-1:0] UPC_DONE           = 4'd12;

  // One control word per program step
  typedef struct packed {
    logic             mul_en;
    a_sel_t           a_sel;
    b_sel_t           b_sel;
    ret_t             ret;
    rom_sel_t         rom_sel;
    logic             sc_load;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
    logic             done;
  } ctrl_t;

  // Sequencer to datapath control group
  typedef struct packed {
    ctrl_t cw;
    logic  en;
    logic  accept;
    logic  out_load;
  } seq_ctrl_t;

  // Control store
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
    ctrl_t c;
    c.mul_en  = 1'b0;
    c.a_sel   = A_STEP;
    c.b_sel   = B_SCAN_MUL;
    c.ret     = RET_NONE;
    c.rom_sel = ROM_NONE;
    c.sc_load = 1'b0;
    c.jmp     = JMP_NONE;
    c.target  = UPC_SCAN_MUL;
    c.done    = 1'b0;
    unique case (upc)
      UPC_SCAN_MUL: begin
        c.mul_en = 1'b1; c.a_sel = A_STEP; c.b_sel = B_SCAN_MUL;
      end
      UPC_STEM_MUL: begin
        c.ret = RET_SCAN;
        c.mul_en = 1'b1; c.a_sel = A_STEP; c.b_sel = B_STEM_MUL;
      end
      UPC_HAT_MUL: begin
        c.ret = RET_STEM;
        c.mul_en = 1'b1; c.a_sel = A_STEP; c.b_sel = B_HAT_MUL;
        c.rom_sel = ROM_SCAN;
      end
      UPC_SAW_MUL: begin
        c.ret = RET_HAT;
        c.mul_en = 1'b1; c.a_sel = A_SAW; c.b_sel = B_SCAN_GAIN;
        c.sc_load = 1'b1;
      end
      UPC_LEFT_READ: begin
        c.ret = RET_RIGHT;
        c.rom_sel = ROM_LEFT;
      end
      UPC_RIGHT_MUL: begin
        c.mul_en = 1'b1; c.a_sel = A_RIGHT; c.b_sel = B_MASTER;
      end
      UPC_LEFT_MUL: begin
        c.ret = RET_RIGHT;
        c.mul_en = 1'b1; c.a_sel = A_SINE; c.b_sel = B_LEFT_GAIN;
      end
      UPC_LEFT_RET: begin
        c.ret = RET_LEFT;
        c.jmp = JMP_STEM; c.target = UPC_MASTER_MUL;
      end
      UPC_SCAN_SINE_MUL: begin
        c.mul_en = 1'b1; c.a_sel = A_LEFT; c.b_sel = B_SCAN_SINE;
      end
      UPC_SCAN_SINE_RET: begin
        c.ret = RET_LEFT_SINE;
      end
      UPC_MASTER_MUL: begin
        c.mul_en = 1'b1; c.a_sel = A_LEFT; c.b_sel = B_MASTER;
      end
      UPC_MASTER_RET: begin
        c.ret = RET_LEFT;
      end
      UPC_DONE: begin
        c.done = 1'b1;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

/* design/dvsg_if.sv */
// ----------------------------------------------------------------------------
// dvsg_if
// Valid/ready channels of the tone generator: sample ticks in, stereo
// samples out.
// ----------------------------------------------------------------------------
interface dvsg_tick_if;
  logic                          valid;
  logic                          ready;
  logic [dvsg_pkg::STEP_W-1:0]   base_step;

  modport source (output valid, output base_step, input ready);
  modport sink   (input valid, input base_step, output ready);
endinterface

interface dvsg_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [dvsg_pkg::OUT_W-1:0] left_sample;
  logic signed [dvsg_pkg::OUT_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* design/dds_vector_shape_generator_unit.sv */
// ----------------------------------------------------------------------------
// dds_vector_shape_generator_unit
// Three-oscillator vector-shape tone generator: one stereo sample per tick.
// ----------------------------------------------------------------------------
// The program jumps past the scan-sine product steps when the stem is drawn, so
// a stem sample is ready sooner than one drawn from the hat-times-scan product.
// A new tick is taken only once the last item is in the output register; all
// products go through the single shared multiplier that the step program walks.
// Reset: accumulators cleared, registers at reset values, output empty.
module dds_vector_shape_generator_unit #(
  parameter int PHASE_BITS       = dvsg_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = dvsg_pkg::SINE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = dvsg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  dvsg_tick_if.sink                      tick,
  dvsg_sample_if.source                  sample,
  input  logic                           cfg_we,
  input  logic [dvsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dvsg_pkg::CFG_W-1:0]     cfg_data
);

  import dvsg_pkg::*;

  seq_ctrl_t                ctrl;
  logic                     stem_side;
  logic                     tick_ready;
  logic                     out_valid;
  logic                     out_busy;
  logic signed [OUT_W-1:0]  left_q;
  logic signed [OUT_W-1:0]  right_q;

  assign out_busy = out_valid && !sample.ready;

  dvsg_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .out_busy   (out_busy),
    .stem_side  (stem_side),
    .tick_ready (tick_ready),
    .ctrl       (ctrl)
  );

  dvsg_datapath #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .base_step    (tick.base_step),
    .ctrl         (ctrl),
    .stem_side    (stem_side),
    .left_sample  (left_q),
    .right_sample (right_q)
  );

  // Output register valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (sample.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign tick.ready          = tick_ready;
  assign sample.valid        = out_valid;
  assign sample.left_sample  = left_q;
  assign sample.right_sample = right_q;

endmodule

/* design/dvsg_sine_rom.sv */
// ----------------------------------------------------------------------------
// dvsg_sine_rom
// Quarter-wave sine table, filled at elaboration, with a registered read.
// ----------------------------------------------------------------------------
module dvsg_sine_rom #(
  parameter int SINE_TABLE_DEPTH = dvsg_pkg::SINE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = dvsg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] rd_idx,
  output logic [SAMPLE_BITS-2:0]              rd_data
);

  localparam int DB     = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_W = SAMPLE_BITS - 1;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_W-1:0] rom_t [SINE_TABLE_DEPTH];

  // Sample sin at the center of each bin: Q30 Taylor series up to x^13
  function automatic rom_t build_rom();
    rom_t              r;
    longint unsigned   amp;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   v;
    longint            sum;
    amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * longint'(2 * k + 1)) >> (DB + 1);
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        case (n)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          default: term = term / 64'd156;
        endcase
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = ((longint'(sum) * amp) + (64'd1 << 29)) >> 30;
      if (v > amp) begin
        v = amp;
      end
      r[k] = SINE_W'(v);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ROM[rd_idx];
    end
  end

endmodule

/* design/dvsg_sequencer.sv */
// ----------------------------------------------------------------------------
// dvsg_sequencer
// Step counter over the control store: takes a tick item, walks the program
// with one conditional jump, and holds on the last step while the output
// register is still full.
// ----------------------------------------------------------------------------
module dvsg_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  input  logic                out_busy,
  input  logic                stem_side,
  output logic                tick_ready,
  output dvsg_pkg::seq_ctrl_t ctrl
);

  import dvsg_pkg::*;

  seq_state_t       state;
  seq_state_t       state_next;
  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  ctrl_t            cw;

  assign cw = ucode(upc);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (tick_valid) begin
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (cw.done && !out_busy) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Next program step
  always_comb begin
    upc_next = upc;
    if (state == SEQ_IDLE) begin
      upc_next = UPC_SCAN_MUL;
    end else if (!cw.done) begin
      if (cw.jmp == JMP_STEM && stem_side) begin
        upc_next = cw.target;
      end else begin
        upc_next = upc + 1'b1;
      end
    end
  end

  // Outputs
  always_comb begin
    tick_ready    = (state == SEQ_IDLE);
    ctrl.cw       = cw;
    ctrl.accept   = (state == SEQ_IDLE) && tick_valid;
    ctrl.en       = (state == SEQ_RUN) && !(cw.done && out_busy);
    ctrl.out_load = (state == SEQ_RUN) && cw.done && !out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      upc   <= UPC_SCAN_MUL;
    end else begin
      state <= state_next;
      upc   <= upc_next;
    end
  end

endmodule

/* design/dvsg_datapath.sv */
// ----------------------------------------------------------------------------
// dvsg_datapath
// Configuration registers, phase accumulators, shared multiplier with
// rounding retire, sine lookup and Q1.15 output conversion.
// ----------------------------------------------------------------------------
module dvsg_datapath #(
  parameter int PHASE_BITS       = dvsg_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = dvsg_pkg::SINE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = dvsg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dvsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dvsg_pkg::CFG_W-1:0]          cfg_data,
  input  logic [dvsg_pkg::STEP_W-1:0]         base_step,
  input  dvsg_pkg::seq_ctrl_t                 ctrl,
  output logic                                stem_side,
  output logic signed [dvsg_pkg::OUT_W-1:0]   left_sample,
  output logic signed [dvsg_pkg::OUT_W-1:0]   right_sample
);

  import dvsg_pkg::*;

  localparam int QB     = PHASE_BITS - 2;
  localparam int DB     = $clog2(SINE_TABLE_DEPTH);
  localparam int MAG_W  = SAMPLE_BITS;
  localparam int SINE_W = SAMPLE_BITS - 1;
  localparam int B_W    = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int P_W    = STEP_W + B_W;
  localparam int INC_W  = STEP_W + 2;
  localparam logic [P_W-1:0] HALF_GAIN = P_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [P_W-1:0] HALF_SINE = P_W'(1) << (SAMPLE_BITS - 2);
  localparam logic [MAG_W-1:0] SAW_HALF = MAG_W'(1) << (MAG_W - 1);

  // Output conversion to Q1.15
  localparam int CV_DN = (SAMPLE_BITS > OUT_W) ? SAMPLE_BITS - OUT_W : 0;
  localparam int CV_UP = (SAMPLE_BITS < OUT_W) ? OUT_W - SAMPLE_BITS : 0;
  localparam int CV_W  = MAG_W + CV_UP + 1;
  localparam logic [CV_W-1:0] CV_HALF = (CV_W'(1) << CV_DN) >> 1;
  localparam logic [CV_W-1:0] Q15_POS = CV_W'(32767);
  localparam logic [CV_W-1:0] Q15_NEG = CV_W'(32768);

  logic [CFG_W-1:0]      cfg_regs [NUM_CFG];
  logic [STEP_W-1:0]     step;
  logic [PHASE_BITS-1:0] scan_acc;
  logic [PHASE_BITS-1:0] stem_acc;
  logic [PHASE_BITS-1:0] hat_acc;
  logic [P_W-1:0]        prod;
  logic                  prod_neg;
  logic [MAG_W-1:0]      r_mag;
  logic                  r_neg;
  logic [MAG_W-1:0]      l_mag;
  logic                  l_neg;
  logic [SINE_W-1:0]     sc_mag;
  logic                  sc_neg;
  logic [SINE_W-1:0]     rom_mag;
  logic                  rom_neg;

  logic [STEP_W-1:0]           mul_a;
  logic                        a_neg;
  logic [B_W-1:0]              mul_b;
  logic                        b_neg;
  logic [PHASE_BITS-1:0]       rd_phase;
  logic [1:0]                  quad;
  logic [QB-1:0]               qoff;
  logic [DB-1:0]               rom_idx;
  logic                        rom_rd;
  logic [PHASE_BITS+MAG_W-1:0] saw_ext;
  logic [MAG_W-1:0]            saw_bits;
  logic [MAG_W-1:0]            saw_mag;
  logic                        saw_neg;
  logic [INC_W-1:0]            inc;
  logic [INC_W+PHASE_BITS-1:0] inc_ext;
  logic [PHASE_BITS-1:0]       inc_al;
  logic [MAG_W-1:0]            gain_rnd;
  logic [MAG_W-1:0]            sine_rnd;

  function automatic logic [OUT_W-1:0] to_q15(input logic [MAG_W-1:0] mag,
                                              input logic neg);
    logic [CV_W-1:0] conv;
    conv = ((CV_W'(mag) + CV_HALF) >> CV_DN) << CV_UP;
    if (neg) begin
      to_q15 = (conv >= Q15_NEG) ? OUT_W'(Q15_NEG) : OUT_W'(-conv);
    end else begin
      to_q15 = (conv > Q15_POS) ? OUT_W'(Q15_POS) : OUT_W'(conv);
    end
  endfunction

  // Left channel draws stem while the scan phase is at or below the fraction
  assign stem_side = {scan_acc, {CFG_W{1'b0}}}
                  <= {cfg_regs[REG_HAT_FRACTION], {PHASE_BITS{1'b0}}};

  // Sawtooth from the top scan phase bits, in sign and magnitude
  always_comb begin
    saw_ext  = {scan_acc, {MAG_W{1'b0}}};
    saw_bits = saw_ext[PHASE_BITS+MAG_W-1 -: MAG_W];
    saw_neg  = !saw_bits[MAG_W-1];
    saw_mag  = saw_bits[MAG_W-1] ? {1'b0, saw_bits[MAG_W-2:0]} : SAW_HALF - saw_bits;
  end

  // Sine address: quadrant fold of the selected phase
  always_comb begin
    rd_phase = (ctrl.cw.rom_sel == ROM_SCAN) ? scan_acc : (stem_side ? stem_acc : hat_acc);
    quad     = rd_phase[PHASE_BITS-1 -: 2];
    qoff     = rd_phase[QB-1:0];
    if (quad[0]) begin
      qoff = ~qoff;
    end
    rom_idx  = qoff[QB-1 -: DB];
    rom_rd   = ctrl.en && (ctrl.cw.rom_sel != ROM_NONE);
  end

  dvsg_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rom_rd),
    .rd_idx  (rom_idx),
    .rd_data (rom_mag)
  );

  // Multiplier operand A
  always_comb begin
    mul_a = step;
    a_neg = 1'b0;
    unique case (ctrl.cw.a_sel)
      A_STEP:  begin mul_a = step;                 a_neg = 1'b0;    end
      A_SAW:   begin mul_a = STEP_W'(saw_mag);     a_neg = saw_neg; end
      A_SINE:  begin mul_a = STEP_W'(rom_mag);     a_neg = rom_neg; end
      A_RIGHT: begin mul_a = STEP_W'(r_mag);       a_neg = r_neg;   end
      A_LEFT:  begin mul_a = STEP_W'(l_mag);       a_neg = l_neg;   end
      default: begin mul_a = step;                 a_neg = 1'b0;    end
    endcase
  end

  // Multiplier operand B
  always_comb begin
    mul_b = '0;
    b_neg = 1'b0;
    unique case (ctrl.cw.b_sel)
      B_SCAN_MUL:  mul_b = B_W'(cfg_regs[REG_SCAN_RATE_MUL]);
      B_STEM_MUL:  mul_b = B_W'(cfg_regs[REG_STEM_RATE_MUL]);
      B_HAT_MUL:   mul_b = B_W'(cfg_regs[REG_HAT_RATE_MUL]);
      B_SCAN_GAIN: mul_b = B_W'(cfg_regs[REG_SCAN_GAIN]);
      B_LEFT_GAIN: mul_b = stem_side ? B_W'(cfg_regs[REG_STEM_GAIN])
                                     : B_W'(cfg_regs[REG_HAT_GAIN]);
      B_MASTER:    mul_b = B_W'(cfg_regs[REG_MASTER_GAIN]);
      B_SCAN_SINE: begin
        mul_b = B_W'(sc_mag);
        b_neg = sc_neg;
      end
      default:     mul_b = '0;
    endcase
  end

  // Retire paths: phase step alignment and rounded magnitudes
  always_comb begin
    inc      = INC_W'(prod >> RATE_FRAC_BITS);
    inc_ext  = {inc, {PHASE_BITS{1'b0}}};
    inc_al   = PHASE_BITS'(inc_ext >> STEP_W);
    gain_rnd = MAG_W'((prod + HALF_GAIN) >> GAIN_FRAC_BITS);
    sine_rnd = MAG_W'((prod + HALF_SINE) >> (SAMPLE_BITS - 1));
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_regs[i] <= CFG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // Phase accumulators: advance by the retired step, wrap on overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_acc <= '0;
      stem_acc <= '0;
      hat_acc  <= '0;
    end else if (ctrl.en) begin
      case (ctrl.cw.ret)
        RET_SCAN: scan_acc <= scan_acc + inc_al;
        RET_STEM: stem_acc <= stem_acc + inc_al;
        RET_HAT:  hat_acc  <= hat_acc + inc_al;
        default:  ;
      endcase
    end
  end

  // Item capture, multiplier, sine sign and scaled term registers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      step <= base_step;
    end
    if (ctrl.en && ctrl.cw.mul_en) begin
      prod     <= P_W'(mul_a) * P_W'(mul_b);
      prod_neg <= a_neg ^ b_neg;
    end
    if (rom_rd) begin
      rom_neg <= quad[1];
    end
    if (ctrl.en && ctrl.cw.sc_load) begin
      sc_mag <= rom_mag;
      sc_neg <= rom_neg;
    end
    if (ctrl.en) begin
      case (ctrl.cw.ret)
        RET_RIGHT: begin
          r_mag <= gain_rnd;
          r_neg <= prod_neg;
        end
        RET_LEFT: begin
          l_mag <= gain_rnd;
          l_neg <= prod_neg;
        end
        RET_LEFT_SINE: begin
          l_mag <= sine_rnd;
          l_neg <= prod_neg;
        end
        default: ;
      endcase
    end
    if (ctrl.out_load) begin
      left_sample  <= to_q15(l_mag, l_neg);
      right_sample <= to_q15(r_mag, r_neg);
    end
  end

endmodule
